[hdl/rtpnal_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the H.264 RTP NAL reassembler.
// No dependencies; imported by every module of the block.
package rtpnal_pkg;

  localparam int FRAME_ID_BITS_DEF = 32;
  localparam int RES_DEPTH         = 4;
  localparam int IN_TDATA_W        = 96;
  localparam int OUT_TDATA_W       = 96;
  localparam int OUT_TUSER_W       = 6;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_UNSUP   = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_NOSTART = 3'd4;
  localparam logic [2:0] ST_TS      = 3'd5;
  localparam logic [2:0] ST_SEQ     = 3'd6;

  // NAL unit types
  localparam logic [4:0] TYPE_FUA = 5'd28;
  localparam logic [4:0] TYPE_MAX = 5'd23;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic        empty_packet;
    logic [31:0] rtp_timestamp;
    logic [15:0] sequence_number;
    logic        marker_bit;
    logic        frame_id_present;
    logic [31:0] frame_tag;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        nal_first;
    logic        nal_last;
    logic [2:0]  status_code;
    logic        discard_partial;
    logic [31:0] nal_timestamp;
    logic [15:0] last_sequence;
    logic        end_of_frame;
    logic        nal_has_frame_id;
    logic [31:0] nal_frame_id;
  } result_t;

  // Builds one result item; trailer fields only ride with nal_last.
  function automatic result_t mk_res(logic [7:0] b, logic valid, logic first, logic last,
                                     logic [2:0] status, logic disc, logic [31:0] ts,
                                     logic [15:0] seq, logic eof, logic hasid,
                                     logic [31:0] fid);
    result_t r;
    r.out_byte         = b;
    r.byte_valid       = valid;
    r.nal_first        = first;
    r.nal_last         = last;
    r.status_code      = status;
    r.discard_partial  = disc;
    r.nal_timestamp    = last ? ts : '0;
    r.last_sequence    = last ? seq : '0;
    r.end_of_frame     = last & eof;
    r.nal_has_frame_id = last & hasid;
    r.nal_frame_id     = (last && hasid) ? fid : '0;
    return r;
  endfunction

endpackage

[hdl/rtpnal_core.sv]
`timescale 1ns / 1ps
// Depacketizer state and per-item decode: single NAL pass-through, FU-A checks
// and header rebuild. Produces up to two result items per input item. Uses rtpnal_pkg.
module rtpnal_core import rtpnal_pkg::*; #(
  parameter int FRAME_ID_BITS = FRAME_ID_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  in_item_t   item,
  output logic [1:0] res_cnt,
  output result_t    res0,
  output result_t    res1
);

  localparam int FID_W = (FRAME_ID_BITS > 32) ? 32 : FRAME_ID_BITS;

  typedef enum logic [1:0] {MODE_IDLE, MODE_SINGLE, MODE_FUA, MODE_DROP} mode_t;

  mode_t            mode, mode_next;
  logic [1:0]       pos, pos_next;
  logic [2:0]       nri, nri_next;
  logic [6:0]       fh, fh_next;
  logic             asm_on, asm_next;
  logic [31:0]      hts, hts_next;
  logic [15:0]      eseq, eseq_next;
  logic [FID_W-1:0] hfid, hfid_next;
  logic             hfv, hfv_next;

  always_comb begin
    logic        disc;
    logic [31:0] tag;
    logic [4:0]  nal_type;
    logic [7:0]  d;
    logic        fb, lb, ep;
    mode_t       pm;
    mode_next = mode;
    pos_next  = pos;
    nri_next  = nri;
    fh_next   = fh;
    asm_next  = asm_on;
    hts_next  = hts;
    eseq_next = eseq;
    hfid_next = hfid;
    hfv_next  = hfv;
    res_cnt   = 2'd0;
    res0      = '0;
    res1      = '0;
    disc      = 1'b0;
    d         = item.data_byte;
    fb        = item.first_byte;
    lb        = item.last_byte;
    ep        = item.empty_packet;
    nal_type  = d[4:0];
    tag       = item.frame_id_present ? 32'(item.frame_tag[FID_W-1:0]) : '0;
    pm        = mode;

    // a new packet closes whatever packet is still open
    if ((fb || ep) && mode != MODE_IDLE) begin
      if (mode == MODE_SINGLE || (mode == MODE_FUA && asm_on)) disc = 1'b1;
      if (mode == MODE_FUA && asm_on) begin
        asm_next  = 1'b0;
        hts_next  = '0;
        eseq_next = '0;
        hfid_next = '0;
        hfv_next  = 1'b0;
      end
      pm        = MODE_IDLE;
      mode_next = MODE_IDLE;
    end

    if (ep) begin
      mode_next = MODE_IDLE;
      pos_next  = 2'd0;
      res0      = mk_res('0, 1'b0, 1'b0, 1'b0, ST_EMPTY, disc, '0, '0, 1'b0, 1'b0, '0);
      res_cnt   = 2'd1;
    end else if (pm == MODE_IDLE && !fb) begin
      res_cnt = 2'd0;
    end else if (fb) begin
      pos_next = 2'd1;
      if (nal_type != 5'd0 && nal_type <= TYPE_MAX) begin
        if (asm_next) begin
          disc      = 1'b1;
          asm_next  = 1'b0;
          hts_next  = '0;
          eseq_next = '0;
          hfid_next = '0;
          hfv_next  = 1'b0;
        end
        if (disc) begin
          res0    = mk_res('0, 1'b0, 1'b0, 1'b0, ST_OK, 1'b1, '0, '0, 1'b0, 1'b0, '0);
          res1    = mk_res(d, 1'b1, 1'b1, lb, ST_OK, 1'b0, item.rtp_timestamp,
                           item.sequence_number, item.marker_bit,
                           item.frame_id_present, tag);
          res_cnt = 2'd2;
        end else begin
          res0    = mk_res(d, 1'b1, 1'b1, lb, ST_OK, 1'b0, item.rtp_timestamp,
                           item.sequence_number, item.marker_bit,
                           item.frame_id_present, tag);
          res_cnt = 2'd1;
        end
        mode_next = lb ? MODE_IDLE : MODE_SINGLE;
      end else if (nal_type == TYPE_FUA) begin
        nri_next = d[7:5];
        if (lb) begin
          if (asm_next) begin
            disc      = 1'b1;
            asm_next  = 1'b0;
            hts_next  = '0;
            eseq_next = '0;
            hfid_next = '0;
            hfv_next  = 1'b0;
          end
          mode_next = MODE_IDLE;
          res0      = mk_res('0, 1'b0, 1'b0, 1'b0, ST_SHORT, disc, '0, '0, 1'b0, 1'b0, '0);
          res_cnt   = 2'd1;
        end else begin
          mode_next = MODE_FUA;
          if (disc) begin
            res0    = mk_res('0, 1'b0, 1'b0, 1'b0, ST_OK, 1'b1, '0, '0, 1'b0, 1'b0, '0);
            res_cnt = 2'd1;
          end
        end
      end else begin
        if (asm_next) begin
          disc      = 1'b1;
          asm_next  = 1'b0;
          hts_next  = '0;
          eseq_next = '0;
          hfid_next = '0;
          hfv_next  = 1'b0;
        end
        mode_next = lb ? MODE_IDLE : MODE_DROP;
        res0      = mk_res('0, 1'b0, 1'b0, 1'b0, ST_UNSUP, disc, '0, '0, 1'b0, 1'b0, '0);
        res_cnt   = 2'd1;
      end
    end else if (pm == MODE_SINGLE) begin
      res0    = mk_res(d, 1'b1, 1'b0, lb, ST_OK, 1'b0, item.rtp_timestamp,
                       item.sequence_number, item.marker_bit, item.frame_id_present, tag);
      res_cnt = 2'd1;
      if (lb) mode_next = MODE_IDLE;
    end else if (pm == MODE_DROP) begin
      if (lb) mode_next = MODE_IDLE;
    end else if (pos == 2'd1) begin
      // FU header byte
      fh_next = d[6:0];
      if (lb) begin
        asm_next  = 1'b0;
        hts_next  = '0;
        eseq_next = '0;
        hfid_next = '0;
        hfv_next  = 1'b0;
        mode_next = MODE_IDLE;
        res0      = mk_res('0, 1'b0, 1'b0, 1'b0, ST_SHORT, asm_on, '0, '0, 1'b0, 1'b0, '0);
        res_cnt   = 2'd1;
      end else begin
        pos_next = 2'd2;
        if (d[7]) begin
          asm_next  = 1'b1;
          hts_next  = item.rtp_timestamp;
          eseq_next = 16'(item.sequence_number + 16'd1);
          hfid_next = tag[FID_W-1:0];
          hfv_next  = item.frame_id_present;
          if (asm_on) begin
            res0    = mk_res('0, 1'b0, 1'b0, 1'b0, ST_OK, 1'b1, '0, '0, 1'b0, 1'b0, '0);
            res1    = mk_res({nri, d[4:0]}, 1'b1, 1'b1, 1'b0, ST_OK, 1'b0,
                             '0, '0, 1'b0, 1'b0, '0);
            res_cnt = 2'd2;
          end else begin
            res0    = mk_res({nri, d[4:0]}, 1'b1, 1'b1, 1'b0, ST_OK, 1'b0,
                             '0, '0, 1'b0, 1'b0, '0);
            res_cnt = 2'd1;
          end
        end else if (!asm_on) begin
          mode_next = MODE_DROP;
          res0      = mk_res('0, 1'b0, 1'b0, 1'b0, ST_NOSTART, 1'b0, '0, '0, 1'b0, 1'b0, '0);
          res_cnt   = 2'd1;
        end else if (item.rtp_timestamp != hts) begin
          asm_next  = 1'b0;
          hts_next  = '0;
          eseq_next = '0;
          hfid_next = '0;
          hfv_next  = 1'b0;
          mode_next = MODE_DROP;
          res0      = mk_res('0, 1'b0, 1'b0, 1'b0, ST_TS, 1'b1, '0, '0, 1'b0, 1'b0, '0);
          res_cnt   = 2'd1;
        end else if (item.sequence_number != eseq) begin
          asm_next  = 1'b0;
          hts_next  = '0;
          eseq_next = '0;
          hfid_next = '0;
          hfv_next  = 1'b0;
          mode_next = MODE_DROP;
          res0      = mk_res('0, 1'b0, 1'b0, 1'b0, ST_SEQ, 1'b1, '0, '0, 1'b0, 1'b0, '0);
          res_cnt   = 2'd1;
        end else begin
          eseq_next = 16'(item.sequence_number + 16'd1);
        end
      end
    end else begin
      // FU-A body byte
      res_cnt = 2'd1;
      res0    = mk_res(d, 1'b1, 1'b0, 1'b0, ST_OK, 1'b0, '0, '0, 1'b0, 1'b0, '0);
      if (lb) begin
        mode_next = MODE_IDLE;
        if (fh[6]) begin
          res0      = mk_res(d, 1'b1, 1'b0, 1'b1, ST_OK, 1'b0, item.rtp_timestamp,
                             item.sequence_number, item.marker_bit, hfv, 32'(hfid));
          asm_next  = 1'b0;
          hts_next  = '0;
          eseq_next = '0;
          hfid_next = '0;
          hfv_next  = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      pos    <= '0;
      nri    <= '0;
      fh     <= '0;
      asm_on <= 1'b0;
      hts    <= '0;
      eseq   <= '0;
      hfid   <= '0;
      hfv    <= 1'b0;
    end else if (go) begin
      mode   <= mode_next;
      pos    <= pos_next;
      nri    <= nri_next;
      fh     <= fh_next;
      asm_on <= asm_next;
      hts    <= hts_next;
      eseq   <= eseq_next;
      hfid   <= hfid_next;
      hfv    <= hfv_next;
    end
  end

endmodule

[hdl/rtpnal_res_fifo.sv]
`timescale 1ns / 1ps
// Small result queue: takes zero, one or two result items per cycle and
// presents them one at a time on the output stream. Uses rtpnal_pkg.
module rtpnal_res_fifo import rtpnal_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_cnt,
  input  result_t    push0,
  input  result_t    push1,
  output logic       room2,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  localparam int PTR_W = $clog2(RES_DEPTH);
  localparam int CNT_W = $clog2(RES_DEPTH + 1);

  result_t            mem [RES_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign room2     = (count <= CNT_W'(RES_DEPTH - 2));
  assign out_res   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem[wr_ptr] <= push0;
    if (push_cnt == 2'd2) mem[PTR_W'(wr_ptr + 1'b1)] <= push1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push_cnt));
      if (pop) rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      count  <= CNT_W'(count + CNT_W'(push_cnt) - CNT_W'(pop));
    end
  end

endmodule

[hdl/h264_rtp_nal_reassembler.sv]
`timescale 1ns / 1ps
// H.264 RTP NAL reassembler top level: input register, decode core, result queue.
// Depends on rtpnal_pkg, rtpnal_core and rtpnal_res_fifo.
//
// Usage:
//  s_axis carries one RTP payload byte per item with its packet context;
//  tlast is the packet's last byte, tuser holds first_byte and empty_packet.
//  m_axis carries the reassembled NAL stream and status items; tlast marks
//  the final byte of a NAL, tuser holds the valid/first/status/discard flags.
//  Each input item yields zero, one or two result items.
// Path: the first result of an item can be taken on m_axis once the item has
//  passed the input register, then the result queue.
// Throughput: one input item per cycle while each item yields at most one
//  result and m_axis is ready; items that yield two results outpace the
//  single-item output port draining the four-entry result queue.
// Reset: clears the depacketizer state and empties both the input register
//  and the result queue; no item is accepted during reset.
// Stall: when m_axis is held off, the queue fills, the decode stage waits for
//  room for two results, and s_axis_tready falls after the input register fills.
module h264_rtp_nal_reassembler import rtpnal_pkg::*; #(
  parameter int FRAME_ID_BITS = FRAME_ID_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // data_byte[7:0], rtp_timestamp[39:8], sequence_number[55:40], marker_bit[56],
  // frame_id_present[57], frame_tag[89:58], zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // first_byte[0], empty_packet[1]
  input  logic [1:0]             s_axis_tuser,
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_byte[7:0], nal_timestamp[39:8], last_sequence[55:40], end_of_frame[56],
  // nal_has_frame_id[57], nal_frame_id[89:58], zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // byte_valid[0], nal_first[1], status_code[4:2], discard_partial[5]
  output logic [OUT_TUSER_W-1:0] m_axis_tuser,
  output logic                   m_axis_tlast
);

  in_item_t   in_item;
  logic       in_valid;
  logic       go;
  logic       room2;
  logic [1:0] res_cnt;
  result_t    res0, res1, out_res;

  assign go            = in_valid && room2;
  assign s_axis_tready = !rst && (!in_valid || go);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.data_byte        <= s_axis_tdata[7:0];
      in_item.first_byte       <= s_axis_tuser[0];
      in_item.last_byte        <= s_axis_tlast;
      in_item.empty_packet     <= s_axis_tuser[1];
      in_item.rtp_timestamp    <= s_axis_tdata[39:8];
      in_item.sequence_number  <= s_axis_tdata[55:40];
      in_item.marker_bit       <= s_axis_tdata[56];
      in_item.frame_id_present <= s_axis_tdata[57];
      in_item.frame_tag        <= s_axis_tdata[89:58];
    end
  end

  rtpnal_core #(
    .FRAME_ID_BITS(FRAME_ID_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (in_item),
    .res_cnt(res_cnt),
    .res0   (res0),
    .res1   (res1)
  );

  rtpnal_res_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (go ? res_cnt : 2'd0),
    .push0    (res0),
    .push1    (res1),
    .room2    (room2),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (out_res)
  );

  assign m_axis_tdata = {6'd0, out_res.nal_frame_id, out_res.nal_has_frame_id,
                         out_res.end_of_frame, out_res.last_sequence,
                         out_res.nal_timestamp, out_res.out_byte};
  assign m_axis_tuser = {out_res.discard_partial, out_res.status_code,
                         out_res.nal_first, out_res.byte_valid};
  assign m_axis_tlast = out_res.nal_last;

endmodule
